// File: src/bkte_pkg.sv
// bkte_pkg: shared types and constants of the boolean key track evaluator
// no dependencies; imported by the top level and by its checker
`default_nettype none

package bkte_pkg;

  // width of the working frame value, wrap sums are kept at this width
  localparam int WORK_W = 32;

  // stream payload layout
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  localparam int KIDX_LSB = 0;
  localparam int KIDX_W   = 6;
  localparam int KFRM_LSB = 6;
  localparam int QFRM_LSB = 22;
  localparam int FIELD_FRAME_W = 16;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int KCNT_W     = 7;

  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_MODE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_MODE   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_COUNT   = 2'd2;

  // request kinds carried in tuser
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

`default_nettype wire

// File: src/bool_key_track_evaluator.sv
// bool_key_track_evaluator: key table and sequenced evaluator of a toggling boolean track
// depends on bkte_pkg; one shared restoring modulo unit and one key memory read port
// a load request writes the key memory and returns nothing; the evaluator stays ready
// a query result follows reading the first and last keys, up to two modulo passes and a scan
// over the keys, and waits out output stalls; one request at a time
// reset (rst, synchronous): mode registers and key count to 0, output empty; key memory kept
`default_nettype none

module bool_key_track_evaluator
  import bkte_pkg::*;
#(
  parameter int MAX_KEYS   = 64,
  parameter int FRAME_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // request stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // key_index[5:0], key_frame[21:6], query_frame[37:22], zero pad
  input  wire logic                  s_tuser,   // cmd
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata    // track_on[0], divide_fault[1], zero pad
);

  localparam int ADDR_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int MCNT_W = $clog2(WORK_W);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_DECIDE,
    ST_MOD,
    ST_RANGE,
    ST_SCAN0,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t state;

  // configuration registers
  logic              repeat_mode;
  logic              loop_mode;
  logic [KCNT_W-1:0] key_count;

  // key memory
  logic [FRAME_BITS-1:0] key_mem [MAX_KEYS];
  logic [FRAME_BITS-1:0] rdata;
  logic [ADDR_W-1:0]     rd_addr;

  // evaluation registers
  logic [WORK_W-1:0]     frame;
  logic [FRAME_BITS-1:0] first;
  logic [FRAME_BITS-1:0] last;
  logic [CNT_W-1:0]      idx;
  logic                  res_on;
  logic                  res_fault;
  logic                  out_on;
  logic                  out_fault;

  // shared modulo unit
  logic [WORK_W-1:0] mod_rem;
  logic [WORK_W-1:0] mod_dvd;
  logic [WORK_W-1:0] mod_div;
  logic [MCNT_W-1:0] mod_cnt;
  logic              mod_then_range;
  logic [WORK_W:0]   mod_trial;
  logic [WORK_W:0]   rem_next;

  // request fields
  logic                  cmd;
  logic [KIDX_W-1:0]     key_index;
  logic [FIELD_FRAME_W-1:0] key_frame;
  logic [FIELD_FRAME_W-1:0] query_frame;
  logic [FRAME_BITS-1:0] key_trim;
  logic [FRAME_BITS-1:0] query_trim;
  logic                  slot_ok;

  logic [CNT_W-1:0]  n_keys;
  logic [CNT_W-1:0]  n_dec;
  logic [CNT_W-1:0]  idx_inc;
  logic [WORK_W-1:0] first_w;
  logic [WORK_W-1:0] last_w;
  logic [WORK_W-1:0] key_w;
  logic [WORK_W-1:0] span;
  logic              accept;

  assign cmd         = s_tuser;
  assign key_index   = s_tdata[KIDX_LSB +: KIDX_W];
  assign key_frame   = s_tdata[KFRM_LSB +: FIELD_FRAME_W];
  assign query_frame = s_tdata[QFRM_LSB +: FIELD_FRAME_W];
  assign key_trim    = FRAME_BITS'(key_frame);
  assign query_trim  = FRAME_BITS'(query_frame);
  assign slot_ok     = 32'(key_index) < 32'(MAX_KEYS);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_fault, out_on};

  // count above the table depth acts as the depth
  assign n_keys  = (32'(key_count) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS) : CNT_W'(key_count);
  assign n_dec   = n_keys - CNT_W'(1);
  assign idx_inc = idx + CNT_W'(1);
  assign first_w = WORK_W'(first);
  assign last_w  = WORK_W'(last);
  assign key_w   = WORK_W'(rdata);
  assign span    = last_w - first_w;

  assign mod_trial = {mod_rem, mod_dvd[WORK_W-1]};
  assign rem_next  = (mod_trial >= {1'b0, mod_div}) ? (mod_trial - {1'b0, mod_div}) : mod_trial;

  // read address for the data wanted in the next state
  always_comb begin
    case (state)
      ST_FIRST: rd_addr = n_dec[ADDR_W-1:0];
      ST_SCAN:  rd_addr = idx_inc[ADDR_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_LOAD && slot_ok) begin
      key_mem[ADDR_W'(key_index)] <= key_trim;
    end
    rdata <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_mode <= 1'b0;
      loop_mode   <= 1'b0;
      key_count   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_REPEAT_MODE: repeat_mode <= cfg_data[0];
        CFG_LOOP_MODE:   loop_mode   <= cfg_data[0];
        CFG_KEY_COUNT:   key_count   <= cfg_data[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // the result state reloads the output itself
      if (m_tvalid && m_tready && state != ST_RESULT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && cmd == CMD_QUERY) begin
            frame     <= WORK_W'(query_trim);
            res_fault <= 1'b0;
            if (n_keys == '0) begin
              res_on <= 1'b1;
              state  <= ST_RESULT;
            end else begin
              state <= ST_FIRST;
            end
          end
        end
        ST_FIRST: begin
          first <= rdata;
          state <= ST_LAST;
        end
        ST_LAST: begin
          last  <= rdata;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!repeat_mode) begin
            state <= ST_RANGE;
          end else if (span == '0) begin
            res_fault <= 1'b1;
            res_on    <= 1'b0;
            state     <= ST_RESULT;
          end else begin
            mod_dvd        <= frame;
            mod_div        <= span;
            mod_rem        <= '0;
            mod_cnt        <= '0;
            mod_then_range <= 1'b1;
            state          <= ST_MOD;
          end
        end
        ST_MOD: begin
          // one quotient bit a cycle, only the remainder is kept
          mod_rem <= rem_next[WORK_W-1:0];
          mod_dvd <= {mod_dvd[WORK_W-2:0], 1'b0};
          mod_cnt <= mod_cnt + MCNT_W'(1);
          if (mod_cnt == MCNT_W'(WORK_W - 1)) begin
            frame <= first_w + rem_next[WORK_W-1:0];
            state <= mod_then_range ? ST_RANGE : ST_SCAN0;
          end
        end
        ST_RANGE: begin
          if (frame < first_w) begin
            if (!loop_mode) begin
              res_on <= 1'b1;
              state  <= ST_RESULT;
            end else begin
              frame <= last_w - first_w + frame;
              state <= ST_SCAN0;
            end
          end else if (frame > last_w) begin
            if (!loop_mode) begin
              res_on <= ~n_keys[0];
              state  <= ST_RESULT;
            end else if (last_w == '0) begin
              res_fault <= 1'b1;
              res_on    <= 1'b0;
              state     <= ST_RESULT;
            end else begin
              mod_dvd        <= frame;
              mod_div        <= last_w;
              mod_rem        <= '0;
              mod_cnt        <= '0;
              mod_then_range <= 1'b0;
              state          <= ST_MOD;
            end
          end else begin
            state <= ST_SCAN0;
          end
        end
        ST_SCAN0: begin
          // key 0 is being read this cycle
          idx   <= '0;
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (key_w < frame) begin
            if (idx_inc == n_keys) begin
              res_on <= ~n_keys[0];
              state  <= ST_RESULT;
            end else begin
              idx <= idx_inc;
            end
          end else begin
            // an exact hit, or a stop at key 0, keeps this key, otherwise the one before it
            res_on <= (idx != '0 && frame != key_w) ? ~idx[0] : idx[0];
            state  <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            out_on    <= res_on;
            out_fault <= res_fault;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/bkte_checker.sv
// bkte_checker: port-level assertions for the boolean key track evaluator
// depends on bkte_pkg; bound to bool_key_track_evaluator at the end of this file
`default_nettype none

module bkte_checker
  import bkte_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  s_tuser,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a fault always reports the track off
  a_fault_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("fault with track on");

  // a query request occupies the evaluator
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_QUERY |=> !s_tready)
    else $error("ready right after a query request");

  // a load request leaves the evaluator ready
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == CMD_LOAD |=> s_tready)
    else $error("busy after a load request");

  // a new result only comes out of a busy evaluator
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while idle");

endmodule

bind bool_key_track_evaluator bkte_checker u_bkte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
